/* rtl/ssp_pkg.sv */
package ssp_pkg;

  localparam int unsigned SERVO_COUNT_DEF = 4;
  localparam int unsigned RESULT_CAP      = 4;
  localparam int unsigned ANGLE_W         = 8;
  localparam int unsigned DUTY_W          = 14;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CNT_W           = $clog2(RESULT_CAP + 1);
  localparam int unsigned EMIT_W          = $clog2(RESULT_CAP);

  localparam int unsigned FULL_ANGLE   = 180;
  localparam int unsigned PULSE_MIN_US = 500;
  localparam int unsigned PULSE_MAX_US = 2500;
  localparam int unsigned PERIOD_US    = 20000;
  localparam int unsigned DUTY_MAX     = (1 << DUTY_W) - 1;

  localparam logic [ANGLE_W-1:0] RESET_ANGLE = 8'd90;
  localparam logic [ANGLE_W-1:0] RESET_MIN   = 8'd0;
  localparam logic [ANGLE_W-1:0] RESET_MAX   = 8'd180;
  localparam logic [ANGLE_W-1:0] RESET_HOME  = 8'd90;
  localparam logic [ANGLE_W-1:0] RESET_STEP  = 8'd2;

  typedef enum logic [2:0] {
    CMD_INSTANT = 3'd0,
    CMD_SMOOTH  = 3'd1,
    CMD_HOME    = 3'd2,
    CMD_TICK    = 3'd3,
    CMD_QUERY   = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_ANGLE    = 2'd0,
    REG_MAX_ANGLE    = 2'd1,
    REG_HOME_ANGLE   = 2'd2,
    REG_STEP_DEGREES = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ALU_CLAMP,
    ALU_STEP
  } alu_op_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [1:0]         servo;
    logic signed [15:0] angle;
  } in_t;

  typedef struct packed {
    logic [1:0]         servo_out;
    logic [ANGLE_W-1:0] angle_out;
    logic [DUTY_W-1:0]  duty;
    logic               moving;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [1:0]         servo_out;
    logic [ANGLE_W-1:0] angle_out;
    logic               moving;
    logic               last;
  } push_t;

  typedef struct packed {
    alu_op_e            op;
    logic signed [15:0] val;
    logic [ANGLE_W-1:0] cur;
    logic [ANGLE_W-1:0] tgt;
  } alu_req_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] res;
    logic               ne;
  } alu_rsp_t;

  typedef logic [DUTY_W-1:0] duty_lut_t [256];

  // pulse = 500 + a*2000/180 us, duty = pulse*16383/20000
  function automatic duty_lut_t calc_duty_lut();
    duty_lut_t   lut;
    int unsigned a;
    int unsigned pulse;
    for (int unsigned i = 0; i < 256; i++) begin
      a      = (i > FULL_ANGLE) ? FULL_ANGLE : i;
      pulse  = PULSE_MIN_US + (a * (PULSE_MAX_US - PULSE_MIN_US)) / FULL_ANGLE;
      lut[i] = DUTY_W'((pulse * DUTY_MAX) / PERIOD_US);
    end
    return lut;
  endfunction

  localparam duty_lut_t DUTY_LUT = calc_duty_lut();

endpackage

/* rtl/servo_slew_position_control.sv */
// Servo position controller with slew limiting and PWM duty output.
// Input channel (in_valid_i / in_stall_o / in_i) takes one request: instant
// move, smooth move, home all, tick or query. The block stalls the input
// while it works on a request; one request is in flight at a time.
// Output channel (out_valid_o / out_stall_i / out_o) gives zero to four
// results per request, each with servo, angle, 14-bit duty, the moving flag
// and last on the final one. Results sit in an output register, so the
// input opens again as soon as the last result is loaded there.
// A request passes through accept, dispatch, the home or tick sweep and
// the moving scan, then gives its results while the output is free. All
// angle math goes through one shared clamp/step unit, one servo entry per
// cycle. Requests with no result finish without the scan or emit phase.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at
// the next edge and are to be made while idle; the block does not enforce it.
// Reset sets every servo's angle and target to 90 and the limits to their
// defaults; no result is pending afterward. A stalled output holds its
// result and the next result waits in the sequencer.
module servo_slew_position_control import ssp_pkg::*; #(
  parameter int unsigned SERVO_COUNT = SERVO_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ANGLE_W-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_o
);

  localparam int unsigned IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_HOME,
    S_TICK,
    S_SCAN,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  logic [ANGLE_W-1:0] min_q, max_q, home_q, step_q;
  logic [ANGLE_W-1:0] lo_sat, hi_sat;

  logic [ANGLE_W-1:0] cur_q [SERVO_COUNT];
  logic [ANGLE_W-1:0] cur_d [SERVO_COUNT];
  logic [ANGLE_W-1:0] tgt_q [SERVO_COUNT];
  logic [ANGLE_W-1:0] tgt_d [SERVO_COUNT];

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  res_cnt_q, res_cnt_d;
  logic [EMIT_W-1:0] emit_q, emit_d;
  logic              moving_q, moving_d;

  cmd_e               cmd_q;
  logic [1:0]         servo_q;
  logic signed [15:0] val_q;
  logic [ANGLE_W-1:0] a_q;
  logic               a_we;

  logic [1:0]         res_srv_q [RESULT_CAP];
  logic [ANGLE_W-1:0] res_ang_q [RESULT_CAP];
  logic               rec;
  logic [1:0]         rec_srv;
  logic [ANGLE_W-1:0] rec_ang;

  logic [IDX_W-1:0]   addr;
  logic [ANGLE_W-1:0] rd_cur, rd_tgt;
  logic               idx_last, rep_ok, servo_ok, accept, emit_last;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic  push_valid, push_ready;
  push_t push;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != S_IDLE;

  assign lo_sat = (min_q > ANGLE_W'(FULL_ANGLE)) ? ANGLE_W'(FULL_ANGLE) : min_q;
  assign hi_sat = (max_q > ANGLE_W'(FULL_ANGLE)) ? ANGLE_W'(FULL_ANGLE) : max_q;

  assign addr      = (state_q == S_START) ? IDX_W'(servo_q) : idx_q;
  assign rd_cur    = cur_q[addr];
  assign rd_tgt    = tgt_q[addr];
  assign idx_last  = idx_q == IDX_W'(SERVO_COUNT - 1);
  assign rep_ok    = (32'(idx_q) < RESULT_CAP) && (res_cnt_q < CNT_W'(RESULT_CAP));
  assign servo_ok  = 32'(servo_q) < SERVO_COUNT;
  assign emit_last = (CNT_W'(emit_q) + CNT_W'(1)) == res_cnt_q;

  ssp_alu u_alu (
    .req_i  (alu_req),
    .lo_i   (lo_sat),
    .hi_i   (hi_sat),
    .step_i (step_q),
    .rsp_o  (alu_rsp)
  );

  always_comb begin
    alu_req.op  = ALU_STEP;
    alu_req.val = val_q;
    alu_req.cur = rd_cur;
    alu_req.tgt = rd_tgt;
    case (state_q)
      S_START: begin
        alu_req.op = ALU_CLAMP;
        if (cmd_q == CMD_HOME) begin
          alu_req.val = $signed({8'd0, home_q});
        end
      end
      S_HOME: alu_req.tgt = a_q;
      default: ;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    tgt_d     = tgt_q;
    idx_d     = idx_q;
    res_cnt_d = res_cnt_q;
    emit_d    = emit_q;
    moving_d  = moving_q;
    a_we      = 1'b0;
    rec       = 1'b0;
    rec_srv   = 2'(idx_q);
    rec_ang   = alu_rsp.res;
    push_valid = 1'b0;
    push.servo_out = res_srv_q[emit_q];
    push.angle_out = res_ang_q[emit_q];
    push.moving    = moving_q;
    push.last      = emit_last;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_cnt_d = '0;
          emit_d    = '0;
          idx_d     = '0;
          state_d   = S_START;
        end
      end
      S_START: begin
        state_d = S_IDLE;
        case (cmd_q)
          CMD_INSTANT: begin
            if (servo_ok) begin
              cur_d[addr] = alu_rsp.res;
              tgt_d[addr] = alu_rsp.res;
              if (alu_rsp.res != rd_cur) begin
                rec     = 1'b1;
                rec_srv = servo_q;
                state_d = S_SCAN;
              end
            end
          end
          CMD_SMOOTH: begin
            if (servo_ok) begin
              tgt_d[addr] = alu_rsp.res;
            end
          end
          CMD_HOME: begin
            a_we    = 1'b1;
            state_d = S_HOME;
          end
          CMD_TICK: state_d = S_TICK;
          CMD_QUERY: begin
            if (servo_ok) begin
              rec     = 1'b1;
              rec_srv = servo_q;
              rec_ang = rd_cur;
              state_d = S_SCAN;
            end
          end
          default: ;
        endcase
      end
      S_HOME: begin
        cur_d[addr] = a_q;
        tgt_d[addr] = a_q;
        rec_ang     = a_q;
        rec         = alu_rsp.ne && rep_ok;
        idx_d       = idx_q + IDX_W'(1);
        if (idx_last) begin
          idx_d   = '0;
          state_d = (rec || res_cnt_q != '0) ? S_SCAN : S_IDLE;
        end
      end
      S_TICK: begin
        if (alu_rsp.ne) begin
          // step the first servo that is off its target toward it, then stop
          cur_d[addr] = alu_rsp.res;
          rec         = rep_ok;
          idx_d       = '0;
          state_d     = rep_ok ? S_SCAN : S_IDLE;
        end else if (idx_last) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_SCAN: begin
        if (alu_rsp.ne || idx_last) begin
          moving_d = alu_rsp.ne;
          state_d  = S_EMIT;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_EMIT: begin
        push_valid = 1'b1;
        if (push_ready) begin
          emit_d = emit_q + EMIT_W'(1);
          if (emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (rec) begin
      res_cnt_d = res_cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      res_cnt_q <= '0;
      emit_q    <= '0;
      moving_q  <= 1'b0;
      min_q     <= RESET_MIN;
      max_q     <= RESET_MAX;
      home_q    <= RESET_HOME;
      step_q    <= RESET_STEP;
      for (int unsigned i = 0; i < SERVO_COUNT; i++) begin
        cur_q[i] <= RESET_ANGLE;
        tgt_q[i] <= RESET_ANGLE;
      end
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      res_cnt_q <= res_cnt_d;
      emit_q    <= emit_d;
      moving_q  <= moving_d;
      cur_q     <= cur_d;
      tgt_q     <= tgt_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_MIN_ANGLE:    min_q  <= cfg_data_i;
          REG_MAX_ANGLE:    max_q  <= cfg_data_i;
          REG_HOME_ANGLE:   home_q <= cfg_data_i;
          REG_STEP_DEGREES: step_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(in_i.command);
      servo_q <= in_i.servo;
      val_q   <= in_i.angle;
    end
    if (a_we) begin
      a_q <= alu_rsp.res;
    end
    if (rec) begin
      res_srv_q[res_cnt_q[EMIT_W-1:0]] <= rec_srv;
      res_ang_q[res_cnt_q[EMIT_W-1:0]] <= rec_ang;
    end
  end

  ssp_outreg u_outreg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_i       (push),
    .push_ready_o (push_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (out_o)
  );

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("request accepted but sequencer stayed idle");

  a_last_ends_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid && push_ready && push.last |=> state_q == S_IDLE)
    else $error("last result loaded but sequencer still busy");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_EMIT))
    else $error("result appeared outside the emit phase");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> (CNT_W'(emit_q) < res_cnt_q))
    else $error("emit index beyond recorded results");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_cur <= ANGLE_W'(FULL_ANGLE) && rd_tgt <= ANGLE_W'(FULL_ANGLE))
    else $error("stored angle above full range");

endmodule

/* rtl/ssp_alu.sv */
module ssp_alu import ssp_pkg::*; (
  input  alu_req_t           req_i,
  input  logic [ANGLE_W-1:0] lo_i,
  input  logic [ANGLE_W-1:0] hi_i,
  input  logic [ANGLE_W-1:0] step_i,
  output alu_rsp_t           rsp_o
);

  logic [ANGLE_W-1:0] st;
  logic [ANGLE_W-1:0] diff;
  logic [ANGLE_W-1:0] clamp_res;
  logic [ANGLE_W-1:0] step_res;
  logic               up;

  always_comb begin
    // a zero step acts as one
    st   = (step_i == '0) ? ANGLE_W'(1) : step_i;
    up   = req_i.tgt > req_i.cur;
    diff = up ? (req_i.tgt - req_i.cur) : (req_i.cur - req_i.tgt);
    if (diff <= st) begin
      step_res = req_i.tgt;
    end else if (up) begin
      step_res = req_i.cur + st;
    end else begin
      step_res = req_i.cur - st;
    end

    // ordered test: lower limit first, then upper
    if (req_i.val < $signed({8'd0, lo_i})) begin
      clamp_res = lo_i;
    end else if (req_i.val > $signed({8'd0, hi_i})) begin
      clamp_res = hi_i;
    end else begin
      clamp_res = req_i.val[ANGLE_W-1:0];
    end

    case (req_i.op)
      ALU_CLAMP: rsp_o.res = clamp_res;
      ALU_STEP:  rsp_o.res = step_res;
      default:   rsp_o.res = step_res;
    endcase
    rsp_o.ne = req_i.cur != req_i.tgt;
  end

endmodule

/* rtl/ssp_outreg.sv */
module ssp_outreg import ssp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  input  push_t push_i,
  output logic  push_ready_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output out_t  out_o
);

  logic valid_q;
  logic valid_d;
  out_t data_q;

  assign push_ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (push_ready_o) begin
      valid_d = push_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // look up the duty on the way in
  always_ff @(posedge clk_i) begin
    if (push_ready_o && push_valid_i) begin
      data_q.servo_out <= push_i.servo_out;
      data_q.angle_out <= push_i.angle_out;
      data_q.duty      <= DUTY_LUT[push_i.angle_out];
      data_q.moving    <= push_i.moving;
      data_q.last      <= push_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

/* tb/sv/tb_servo_slew_position_control.sv */
`timescale 1ns / 1ps

module tb_servo_slew_position_control import ssp_pkg::*; ();

  class servo_report_board;
    localparam int SERVOS = 4;

    logic [ANGLE_W-1:0] min_a;
    logic [ANGLE_W-1:0] max_a;
    logic [ANGLE_W-1:0] home_a;
    logic [ANGLE_W-1:0] step_a;
    logic [ANGLE_W-1:0] cur_angle [SERVOS];
    logic [ANGLE_W-1:0] tgt_angle [SERVOS];
    out_t               expected_reports [$];
    int                 mismatch_count;

    function new();
      min_a  = 8'd0;
      max_a  = 8'd180;
      home_a = 8'd90;
      step_a = 8'd2;
      for (int i = 0; i < SERVOS; i++) begin
        cur_angle[i] = 8'd90;
        tgt_angle[i] = 8'd90;
      end
      mismatch_count = 0;
    endfunction

    task flag_mismatch(string what, int got, int want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
    endtask

    function int unsigned duty_for(int unsigned a);
      int unsigned pulse;
      pulse = 500 + (a * 2000) / 180;
      return (pulse * 16383) / 20000;
    endfunction

    // limits above full scale saturate; when crossed, angles below the low limit get it, all others the high limit
    function logic [ANGLE_W-1:0] clamp_angle(int a);
      int lo;
      int hi;
      lo = (min_a > 8'd180) ? 180 : int'(min_a);
      hi = (max_a > 8'd180) ? 180 : int'(max_a);
      if (a < lo) return ANGLE_W'(lo);
      if (a > hi) return ANGLE_W'(hi);
      return ANGLE_W'(a);
    endfunction

    function out_t report_for(int s);
      out_t r;
      r.servo_out = 2'(s);
      r.angle_out = cur_angle[s];
      r.duty      = DUTY_W'(duty_for(cur_angle[s]));
      r.moving    = 1'b0;
      r.last      = 1'b0;
      return r;
    endfunction

    function void take_request(in_t req);
      out_t               batch [$];
      logic [ANGLE_W-1:0] a;
      int                 req_angle;
      int                 st;
      int                 c;
      int                 t;
      int                 d;
      bit                 changed;
      bit                 moving;
      int                 s;
      s = int'(req.servo);
      req_angle = $signed(req.angle);
      case (req.command)
        CMD_INSTANT: begin
          a = clamp_angle(req_angle);
          changed = (a != cur_angle[s]);
          cur_angle[s] = a;
          tgt_angle[s] = a;
          if (changed) batch.push_back(report_for(s));
        end
        CMD_SMOOTH: tgt_angle[s] = clamp_angle(req_angle);
        CMD_HOME: begin
          a = clamp_angle(int'(home_a));
          for (int i = 0; i < SERVOS; i++) begin
            changed = (a != cur_angle[i]);
            cur_angle[i] = a;
            tgt_angle[i] = a;
            if (changed) batch.push_back(report_for(i));
          end
        end
        CMD_TICK: begin
          st = (step_a == 8'd0) ? 1 : int'(step_a);
          for (int i = 0; i < SERVOS; i++) begin
            if (cur_angle[i] != tgt_angle[i]) begin
              c = int'(cur_angle[i]);
              t = int'(tgt_angle[i]);
              d = (t > c) ? t - c : c - t;
              if (d <= st) c = t;
              else if (t > c) c = c + st;
              else c = c - st;
              cur_angle[i] = ANGLE_W'(c);
              batch.push_back(report_for(i));
              break;
            end
          end
        end
        CMD_QUERY: batch.push_back(report_for(s));
        default: ;
      endcase
      moving = 1'b0;
      for (int i = 0; i < SERVOS; i++)
        if (cur_angle[i] != tgt_angle[i]) moving = 1'b1;
      foreach (batch[k]) begin
        batch[k].moving = moving;
        batch[k].last   = (k == batch.size() - 1);
        expected_reports.push_back(batch[k]);
      end
    endfunction

    task check_report(out_t got);
      out_t want;
      if (expected_reports.size() == 0) begin
        flag_mismatch("result with nothing expected, angle", got.angle_out, 0);
        return;
      end
      want = expected_reports.pop_front();
      if (got.servo_out !== want.servo_out)
        flag_mismatch("servo_out", got.servo_out, want.servo_out);
      if (got.angle_out !== want.angle_out)
        flag_mismatch("angle_out", got.angle_out, want.angle_out);
      if (got.duty !== want.duty)
        flag_mismatch("duty", got.duty, want.duty);
      if (got.moving !== want.moving)
        flag_mismatch("moving", got.moving, want.moving);
      if (got.last !== want.last)
        flag_mismatch("last", got.last, want.last);
    endtask

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  localparam int QUIET_LIMIT = 600;
  localparam int IDLE_TAIL   = 16;
  localparam int PHASE_ITEMS = 16;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = REG_MIN_ANGLE;
  logic [ANGLE_W-1:0]   cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_t                  in_i        = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_t                 out_o;

  servo_report_board sb;
  int                quiet_cycles = 0;

  servo_slew_position_control u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else begin
      if (in_valid_i && !in_stall_o) sb.take_request(in_i);
      if (out_valid_o && !out_stall_i) sb.check_report(out_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("servo_slew_position_control verification failed");
    $finish;
  end

  // receiver back-pressure: mostly short stalls, a few long ones, some free runs
  initial begin
    int roll;
    wait (rst_ni === 1'b1);
    forever begin
      roll = $urandom_range(0, 99);
      out_stall_i <= 1'b0;
      if (roll < 12) begin
        repeat ($urandom_range(30, 60)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b1;
        if (roll < 20) repeat ($urandom_range(10, 40)) @(posedge clk_i);
        else repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] pick_angle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 16'($urandom_range(0, 200));
    if (roll < 85) return 16'(int'($urandom_range(0, 300)) - 50);
    return 16'($urandom());
  endfunction

  function automatic in_t mk_request(logic [2:0] cmd, logic [1:0] servo,
                                     logic signed [15:0] angle);
    in_t r;
    r.command = cmd;
    r.servo   = servo;
    r.angle   = angle;
    return r;
  endfunction

  // gap 0 keeps valid high so the next request follows back to back
  task automatic send_request(in_t req, int gap);
    in_valid_i <= 1'b1;
    in_i       <= req;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // requests with no result may still be in flight: wait out their latency too
  task automatic settle();
    hold_until_drained();
    repeat (IDLE_TAIL) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [ANGLE_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [7:0] lo, logic [7:0] hi, logic [7:0] home,
                            logic [7:0] step);
    write_reg(REG_MIN_ANGLE, lo);
    write_reg(REG_MAX_ANGLE, hi);
    write_reg(REG_HOME_ANGLE, home);
    write_reg(REG_STEP_DEGREES, step);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    sb.min_a  = lo;
    sb.max_a  = hi;
    sb.home_a = home;
    sb.step_a = step;
  endtask

  task automatic run_directed();
    // reset settings: extremes of the angle, slewing, home, query, unused codes
    send_request(mk_request(CMD_QUERY, 2'd0, 16'sd0), pick_gap());
    send_request(mk_request(CMD_INSTANT, 2'd0, -16'sd32768), pick_gap());
    send_request(mk_request(CMD_INSTANT, 2'd1, 16'sd32767), pick_gap());
    send_request(mk_request(CMD_INSTANT, 2'd1, 16'sd200), pick_gap());
    send_request(mk_request(CMD_SMOOTH, 2'd2, 16'sd99), pick_gap());
    send_request(mk_request(CMD_SMOOTH, 2'd3, 16'sd85), pick_gap());
    repeat (6) send_request(mk_request(CMD_TICK, 2'd0, 16'sd0), pick_gap());
    send_request(mk_request(CMD_HOME, 2'd3, 16'sd0), pick_gap());
    send_request(mk_request(CMD_HOME, 2'd0, 16'sd0), pick_gap());
    send_request(mk_request(CMD_TICK, 2'd1, 16'sd0), pick_gap());
    send_request(mk_request(3'd5, 2'd3, 16'sh7fff), pick_gap());
    send_request(mk_request(3'd6, 2'd2, 16'sh8000), pick_gap());
    send_request(mk_request(3'd7, 2'd1, -16'sd1), pick_gap());
    send_request(mk_request(CMD_QUERY, 2'd3, 16'sd0), pick_gap());
    settle();
    // limits above full scale, zero step
    set_config(8'd200, 8'd255, 8'd255, 8'd0);
    send_request(mk_request(CMD_INSTANT, 2'd0, 16'sd5), pick_gap());
    send_request(mk_request(CMD_HOME, 2'd0, 16'sd0), pick_gap());
    settle();
    // crossed limits, zero step slews one degree per tick
    set_config(8'd150, 8'd20, 8'd0, 8'd0);
    send_request(mk_request(CMD_SMOOTH, 2'd2, 16'sd100), pick_gap());
    send_request(mk_request(CMD_INSTANT, 2'd1, 16'sd160), pick_gap());
    repeat (2) send_request(mk_request(CMD_TICK, 2'd0, 16'sd0), pick_gap());
    send_request(mk_request(CMD_HOME, 2'd0, 16'sd0), pick_gap());
    settle();
  endtask

  task automatic run_random_phase();
    int count;
    int no_idle_left;
    int roll;
    int gap;
    int ticks;
    in_t req;
    in_t seq [$];
    count = 0;
    no_idle_left = 0;
    while (count < PHASE_ITEMS) begin
      seq.delete();
      roll = $urandom_range(0, 99);
      if (roll < 15) no_idle_left = 12;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        // smooth targets followed by the ticks that slew toward them
        seq.push_back(mk_request(CMD_SMOOTH, 2'($urandom_range(0, 3)), pick_angle()));
        if ($urandom_range(0, 2) == 0)
          seq.push_back(mk_request(CMD_SMOOTH, 2'($urandom_range(0, 3)), pick_angle()));
        ticks = $urandom_range(2, 8);
        repeat (ticks)
          seq.push_back(mk_request(CMD_TICK, 2'($urandom()), 16'($urandom())));
      end else begin
        roll = $urandom_range(0, 99);
        req = mk_request(CMD_INSTANT, 2'($urandom_range(0, 3)), pick_angle());
        if (roll >= 40) req.command = CMD_TICK;
        if (roll >= 60) req.command = CMD_HOME;
        if (roll >= 72) req.command = CMD_QUERY;
        if (roll >= 88) req.command = 3'($urandom_range(5, 7));
        seq.push_back(req);
      end
      foreach (seq[k]) begin
        gap = (no_idle_left > 0) ? 0 : pick_gap();
        if (no_idle_left > 0) no_idle_left--;
        send_request(seq[k], gap);
        count++;
        if (count == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 0) hold_until_drained();
      end
    end
    settle();
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_config(8'd0, 8'd180, 8'd0, 8'd1);
        1: set_config(8'd40, 8'd120, 8'd180, 8'd7);
        2: set_config(8'd150, 8'd20, 8'd75, 8'd180);
        3: set_config(8'd0, 8'd0, 8'd255, 8'd255);
        default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 12)));
      endcase
      if (p == 0) hold_until_drained();
      run_random_phase();
    end
    repeat (IDLE_TAIL) @(posedge clk_i);
    if (sb.pending() != 0) sb.flag_mismatch("results never delivered", 0, sb.pending());
    if (sb.mismatch_count == 0) $display("servo_slew_position_control verification clean");
    else $display("servo_slew_position_control verification failed");
    $finish;
  end

endmodule
